// ----- sv/vps_pkg.sv -----
// ----------------------------------------------------------------------------
// vps_pkg
// Shared types, constants and step tables of the vibration pattern sequencer.
// ----------------------------------------------------------------------------
package vps_pkg;

  localparam int TIME_BITS = 32;
  localparam int NOW_BITS  = 32;
  localparam int DUR_BITS  = 10;
  localparam int IDX_BITS  = 3;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_STOP  = 2'd2
  } func_t;

  typedef struct packed {
    logic [1:0]           func;
    logic [1:0]           pattern_select;
    logic                 repeat_mode;
    logic [TIME_BITS-1:0] now;
  } item_t;

  typedef struct packed {
    logic                 is_active;
    logic                 repeat_flag;
    logic [1:0]           pattern_id;
    logic [IDX_BITS-1:0]  step_index;
    logic [TIME_BITS-1:0] deadline_ms;
    logic                 phase_on;
  } state_t;

  // Selector three falls back to pattern 0.
  function automatic logic [1:0] step_row(input logic [1:0] sel);
    logic [1:0] row;
    case (sel)
      2'd1:    row = 2'd1;
      2'd2:    row = 2'd2;
      default: row = 2'd0;
    endcase
    return row;
  endfunction

  function automatic logic [IDX_BITS-1:0] step_len(input logic [1:0] row);
    logic [IDX_BITS-1:0] len;
    case (row)
      2'd1:    len = IDX_BITS'(6);
      default: len = IDX_BITS'(4);
    endcase
    return len;
  endfunction

  function automatic logic [DUR_BITS-1:0] step_dur(input logic [1:0] row,
                                                   input logic [IDX_BITS-1:0] idx);
    logic [DUR_BITS-1:0] dur;
    case (row)
      2'd1: begin
        case (idx)
          3'd0, 3'd2, 3'd4: dur = DUR_BITS'(400);
          3'd1, 3'd3:       dur = DUR_BITS'(200);
          default:          dur = DUR_BITS'(800);
        endcase
      end
      2'd2: begin
        case (idx)
          3'd0, 3'd1, 3'd2: dur = DUR_BITS'(400);
          default:          dur = DUR_BITS'(800);
        endcase
      end
      default: begin
        case (idx)
          3'd0, 3'd1, 3'd2: dur = DUR_BITS'(200);
          default:          dur = DUR_BITS'(800);
        endcase
      end
    endcase
    return dur;
  endfunction

endpackage

// ----- sv/vps_if.sv -----
// ----------------------------------------------------------------------------
// vps_in_if / vps_out_if
// Valid/ready channels for commands and results of the pattern sequencer.
// ----------------------------------------------------------------------------
interface vps_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  func;
  logic [1:0]                  pattern_select;
  logic                        repeat_mode;
  logic [vps_pkg::NOW_BITS-1:0] now_ms;

  modport source (output valid, func, pattern_select, repeat_mode, now_ms, input ready);
  modport sink   (input valid, func, pattern_select, repeat_mode, now_ms, output ready);
endinterface

interface vps_out_if;
  logic valid;
  logic ready;
  logic motor_drive;
  logic running;

  modport source (output valid, motor_drive, running, input ready);
  modport sink   (input valid, motor_drive, running, output ready);
endinterface

// ----- sv/vibration_pattern_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// vibration_pattern_sequencer_unit
// Vibration motor pattern sequencer with valid/ready command and result ports.
// ----------------------------------------------------------------------------
// Accepts one command transaction per clock while the result port is not
// stalled and returns exactly one result transaction per command: it is
// held in the input register, then the state and the result register update.
// The throughput of one item per cycle is set by the combinational next-state
// path (deadline compare, step-table lookup and deadline add). Results come
// back in command order; a stalled result port holds the result register and
// backs up into the input register before the command port deasserts ready.
module vibration_pattern_sequencer_unit (
  input  logic            clk,
  input  logic            rst,
  vps_in_if.sink          items,
  vps_out_if.source       results
);

  logic            s1_valid;
  vps_pkg::item_t  s1_item;
  vps_pkg::state_t state;
  vps_pkg::state_t state_next;
  logic            out_valid;
  logic            out_motor;
  logic            out_running;
  logic            advance;

  assign advance     = s1_valid && (!out_valid || results.ready);
  assign items.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (items.ready) begin
      s1_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.ready && items.valid) begin
      s1_item.func           <= items.func;
      s1_item.pattern_select <= items.pattern_select;
      s1_item.repeat_mode    <= items.repeat_mode;
      s1_item.now            <= vps_pkg::TIME_BITS'(items.now_ms);
    end
  end

  vps_step_logic u_step (
    .item       (s1_item),
    .state      (state),
    .state_next (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_motor   <= state_next.is_active & state_next.phase_on;
      out_running <= state_next.is_active;
    end
  end

  assign results.valid       = out_valid;
  assign results.motor_drive = out_motor;
  assign results.running     = out_running;

endmodule

// ----- sv/vps_step_logic.sv -----
// ----------------------------------------------------------------------------
// vps_step_logic
// Next-state logic: applies one tick, start or stop command to the state.
// ----------------------------------------------------------------------------
module vps_step_logic (
  input  vps_pkg::item_t  item,
  input  vps_pkg::state_t state,
  output vps_pkg::state_t state_next
);

  logic [1:0]                       row;
  logic [vps_pkg::IDX_BITS-1:0]     len;
  logic [vps_pkg::IDX_BITS-1:0]     idx;
  logic [vps_pkg::IDX_BITS-1:0]     idx_inc;
  logic [vps_pkg::TIME_BITS-1:0]    dl_step;
  logic [vps_pkg::TIME_BITS-1:0]    dl_first;
  logic                             due;

  always_comb begin
    row      = vps_pkg::step_row(state.pattern_id);
    len      = vps_pkg::step_len(row);
    // Clamp a stray index to the last step of the pattern.
    idx      = (state.step_index >= len) ? len - 1'b1 : state.step_index;
    idx_inc  = idx + 1'b1;
    dl_step  = item.now + vps_pkg::TIME_BITS'(vps_pkg::step_dur(row, idx));
    dl_first = item.now + vps_pkg::TIME_BITS'(vps_pkg::step_dur(row, '0));
    due      = state.is_active && (item.now >= state.deadline_ms);

    state_next = state;
    case (item.func)
      vps_pkg::FUNC_TICK: begin
        if (due) begin
          state_next.step_index = idx_inc;
          if (idx_inc >= len) begin
            if (state.repeat_flag) begin
              // Wrap to the first step, back in the on phase.
              state_next.step_index  = '0;
              state_next.phase_on    = 1'b1;
              state_next.deadline_ms = dl_first;
            end else begin
              state_next.phase_on    = ~state.phase_on;
              state_next.deadline_ms = dl_step;
              state_next.is_active   = 1'b0;
            end
          end else begin
            state_next.phase_on    = ~state.phase_on;
            state_next.deadline_ms = dl_step;
          end
        end
      end
      vps_pkg::FUNC_START: begin
        state_next.is_active   = 1'b1;
        state_next.repeat_flag = item.repeat_mode;
        state_next.pattern_id  = item.pattern_select;
        state_next.step_index  = '0;
        state_next.phase_on    = 1'b1;
        state_next.deadline_ms = item.now;
      end
      vps_pkg::FUNC_STOP: begin
        // Phase holds; the motor is gated off by is_active.
        state_next.is_active = 1'b0;
      end
      default: begin
        state_next = state;
      end
    endcase
  end

endmodule

// ----- tb/sv/vibration_pattern_sequencer_unit_tb.sv -----
// ----------------------------------------------------------------------------
// vibration_pattern_sequencer_unit_tb
// Self-checking bench for the vibration pattern sequencer. A short table of
// commands walks through the idle, wrap and end-of-pattern cases. Random
// start/tick trains with some noise follow, run over four idling mixes on
// the command and result channels. Each result is checked field by field,
// against fixed table rows, else an in-bench model of the step sequencer.
// ----------------------------------------------------------------------------
module vibration_pattern_sequencer_unit_tb;

  localparam logic [1:0]  FUNC_NOP       = 2'd3;
  localparam int unsigned STALL_LIMIT    = 2000;
  localparam int unsigned ITEMS_PER_MIX  = 450;
  localparam int unsigned DRAIN_CYCLES   = 6;

  // On/off durations in ms per pattern row, and the step count of each row.
  localparam int unsigned PULSE_MS [3][6] = '{
    '{200, 200, 200, 800,   0,   0},
    '{400, 200, 400, 200, 400, 800},
    '{400, 400, 400, 800,   0,   0}
  };
  localparam int unsigned PULSE_COUNT [3] = '{4, 6, 4};
  localparam int unsigned JUMP_MS [3] = '{200, 400, 800};

  typedef struct packed {
    logic motor_drive;
    logic running;
  } motor_state_t;

  typedef struct packed {
    vps_pkg::item_t cmd;
    bit             fixed;
    logic           motor_drive;
    logic           running;
  } plan_row_t;

  localparam int unsigned PLAN_LEN = 27;
  localparam plan_row_t OPENING_PLAN [PLAN_LEN] = '{
    '{'{vps_pkg::FUNC_TICK,  2'd0, 1'b0, 32'd0},          1'b1, 1'b0, 1'b0},
    '{'{FUNC_NOP,            2'd3, 1'b1, 32'hFFFF_FFFF},  1'b1, 1'b0, 1'b0},
    '{'{vps_pkg::FUNC_STOP,  2'd0, 1'b0, 32'd0},          1'b1, 1'b0, 1'b0},
    '{'{vps_pkg::FUNC_START, 2'd0, 1'b0, 32'd1000},       1'b1, 1'b1, 1'b1},
    '{'{vps_pkg::FUNC_TICK,  2'd0, 1'b0, 32'd999},        1'b1, 1'b1, 1'b1},
    '{'{vps_pkg::FUNC_TICK,  2'd0, 1'b0, 32'd1000},       1'b1, 1'b0, 1'b1},
    '{'{vps_pkg::FUNC_TICK,  2'd0, 1'b0, 32'd1200},       1'b0, 1'b0, 1'b0},
    '{'{vps_pkg::FUNC_TICK,  2'd0, 1'b0, 32'd1400},       1'b0, 1'b0, 1'b0},
    '{'{vps_pkg::FUNC_TICK,  2'd0, 1'b0, 32'd1600},       1'b0, 1'b0, 1'b0},
    '{'{vps_pkg::FUNC_START, 2'd3, 1'b1, 32'hFFFF_FF00},  1'b1, 1'b1, 1'b1},
    '{'{vps_pkg::FUNC_TICK,  2'd0, 1'b0, 32'hFFFF_FFFF},  1'b1, 1'b0, 1'b1},
    '{'{vps_pkg::FUNC_TICK,  2'd0, 1'b0, 32'd0},          1'b0, 1'b0, 1'b0},
    '{'{vps_pkg::FUNC_TICK,  2'd0, 1'b0, 32'd199},        1'b0, 1'b0, 1'b0},
    '{'{FUNC_NOP,            2'd0, 1'b0, 32'd0},          1'b0, 1'b0, 1'b0},
    '{'{vps_pkg::FUNC_START, 2'd1, 1'b1, 32'd0},          1'b1, 1'b1, 1'b1},
    '{'{vps_pkg::FUNC_TICK,  2'd0, 1'b0, 32'd10000},      1'b0, 1'b0, 1'b0},
    '{'{vps_pkg::FUNC_TICK,  2'd0, 1'b0, 32'd11000},      1'b0, 1'b0, 1'b0},
    '{'{vps_pkg::FUNC_TICK,  2'd0, 1'b0, 32'd12000},      1'b0, 1'b0, 1'b0},
    '{'{vps_pkg::FUNC_TICK,  2'd0, 1'b0, 32'd13000},      1'b0, 1'b0, 1'b0},
    '{'{vps_pkg::FUNC_TICK,  2'd0, 1'b0, 32'd14000},      1'b0, 1'b0, 1'b0},
    '{'{vps_pkg::FUNC_TICK,  2'd0, 1'b0, 32'd15000},      1'b0, 1'b0, 1'b0},
    '{'{vps_pkg::FUNC_STOP,  2'd1, 1'b1, 32'd15000},      1'b1, 1'b0, 1'b0},
    '{'{vps_pkg::FUNC_START, 2'd2, 1'b0, 32'hFFFF_FFFF},  1'b1, 1'b1, 1'b1},
    '{'{vps_pkg::FUNC_TICK,  2'd0, 1'b0, 32'hFFFF_FFFF},  1'b1, 1'b0, 1'b1},
    '{'{vps_pkg::FUNC_TICK,  2'd0, 1'b0, 32'd399},        1'b0, 1'b0, 1'b0},
    '{'{vps_pkg::FUNC_TICK,  2'd0, 1'b0, 32'd800},        1'b0, 1'b0, 1'b0},
    '{'{vps_pkg::FUNC_TICK,  2'd0, 1'b0, 32'd2000},       1'b0, 1'b0, 1'b0}
  };

  logic clk;
  logic rst;

  vps_in_if  cmd_if ();
  vps_out_if res_if ();

  vibration_pattern_sequencer_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .items   (cmd_if),
    .results (res_if)
  );

  // Sequencer state as the bench sees it.
  logic                          seq_active;
  logic                          seq_repeat;
  logic [1:0]                    seq_pattern;
  logic [vps_pkg::IDX_BITS-1:0]  seq_step;
  logic [vps_pkg::TIME_BITS-1:0] seq_deadline;
  logic                          seq_phase_on;

  plan_row_t    pending_cmds [$];
  motor_state_t motor_expect_q [$];

  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned error_count;
  int unsigned stall_cycles;
  int unsigned result_count;
  logic [vps_pkg::TIME_BITS-1:0] cur_ms;

  always #4 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("mismatch at result %0d: %s", result_count, what);
    error_count++;
  endtask

  function automatic motor_state_t advance_sequencer(input vps_pkg::item_t cmd);
    int unsigned  row;
    int unsigned  len;
    int unsigned  idx;
    motor_state_t r;
    case (cmd.func)
      vps_pkg::FUNC_TICK: begin
        row = (seq_pattern == 2'd1) ? 1 : (seq_pattern == 2'd2) ? 2 : 0;
        len = PULSE_COUNT[row];
        // Plain unsigned compare: no wrap handling on the deadline.
        if (seq_active && !(cmd.now < seq_deadline)) begin
          idx = 32'(seq_step);
          if (idx >= len) idx = len - 1;
          seq_phase_on = !seq_phase_on;
          seq_deadline = cmd.now + vps_pkg::TIME_BITS'(PULSE_MS[row][idx]);
          idx++;
          if (idx >= len) begin
            if (seq_repeat) begin
              idx          = 0;
              seq_phase_on = 1'b1;
              seq_deadline = cmd.now + vps_pkg::TIME_BITS'(PULSE_MS[row][0]);
            end else begin
              seq_active = 1'b0;
            end
          end
          seq_step = vps_pkg::IDX_BITS'(idx);
        end
      end
      vps_pkg::FUNC_START: begin
        seq_active   = 1'b1;
        seq_repeat   = cmd.repeat_mode;
        seq_pattern  = cmd.pattern_select;
        seq_step     = '0;
        seq_phase_on = 1'b1;
        seq_deadline = cmd.now;
      end
      vps_pkg::FUNC_STOP: seq_active = 1'b0;
      default: ;
    endcase
    r.motor_drive = seq_active & seq_phase_on;
    r.running     = seq_active;
    return r;
  endfunction

  // Hold valid across back-to-back transactions; drop it only in a gap.
  task automatic drive_command(input vps_pkg::item_t cmd, input bit fixed,
                               input logic motor, input logic run);
    plan_row_t row;
    row.cmd         = cmd;
    row.fixed       = fixed;
    row.motor_drive = motor;
    row.running     = run;
    while ($urandom_range(99) < src_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid          <= 1'b1;
    cmd_if.func           <= cmd.func;
    cmd_if.pattern_select <= cmd.pattern_select;
    cmd_if.repeat_mode    <= cmd.repeat_mode;
    cmd_if.now_ms         <= cmd.now;
    pending_cmds.push_back(row);
    do @(posedge clk); while (!cmd_if.ready);
  endtask

  task automatic run_random_mix(input int unsigned n_items);
    int unsigned    issued;
    int unsigned    pick;
    int unsigned    n_ticks;
    int unsigned    jump;
    vps_pkg::item_t cmd;
    issued = 0;
    while (issued < n_items) begin
      pick               = $urandom_range(99);
      cmd.pattern_select = 2'($urandom_range(3));
      cmd.repeat_mode    = 1'($urandom_range(1));
      cmd.now            = $urandom();
      if (pick < 5) begin
        cmd.func = FUNC_NOP;
        drive_command(cmd, 1'b0, 1'b0, 1'b0);
        issued++;
      end else if (pick < 13) begin
        cmd.func = (pick < 9) ? vps_pkg::FUNC_STOP : vps_pkg::FUNC_TICK;
        drive_command(cmd, 1'b0, 1'b0, 1'b0);
        issued++;
      end else begin
        // Start a pattern, then feed it a train of ticks.
        case ($urandom_range(9))
          0:       cur_ms = $urandom();
          1:       cur_ms = 32'hFFFF_FFFF - $urandom_range(2047);
          default: cur_ms = cur_ms + $urandom_range(50);
        endcase
        cmd.func = vps_pkg::FUNC_START;
        cmd.now  = cur_ms;
        drive_command(cmd, 1'b0, 1'b0, 1'b0);
        issued++;
        n_ticks = $urandom_range(3, 16);
        for (int unsigned k = 0; k < n_ticks; k++) begin
          jump = $urandom_range(99);
          if (jump < 25)      cur_ms = cur_ms + JUMP_MS[$urandom_range(2)];
          else if (jump < 50) cur_ms = cur_ms + $urandom_range(199);
          else                cur_ms = cur_ms + $urandom_range(200, 900);
          cmd.pattern_select = 2'($urandom_range(3));
          cmd.repeat_mode    = 1'($urandom_range(1));
          cmd.now            = cur_ms;
          cmd.func           = ($urandom_range(99) < 3) ? vps_pkg::FUNC_STOP
                                                        : vps_pkg::FUNC_TICK;
          drive_command(cmd, 1'b0, 1'b0, 1'b0);
          issued++;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    res_if.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk) begin : scoreboard
    plan_row_t      row;
    vps_pkg::item_t seen;
    motor_state_t   got;
    motor_state_t   want;
    if (!rst && cmd_if.valid && cmd_if.ready) begin
      seen.func           = cmd_if.func;
      seen.pattern_select = cmd_if.pattern_select;
      seen.repeat_mode    = cmd_if.repeat_mode;
      seen.now            = cmd_if.now_ms;
      got = advance_sequencer(seen);
      row.fixed = 1'b0;
      if (pending_cmds.size() != 0) row = pending_cmds.pop_front();
      if (row.fixed) begin
        got.motor_drive = row.motor_drive;
        got.running     = row.running;
      end
      motor_expect_q.push_back(got);
    end
    if (!rst && res_if.valid && res_if.ready) begin
      if (motor_expect_q.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        want = motor_expect_q.pop_front();
        if (res_if.motor_drive !== want.motor_drive)
          report_mismatch($sformatf("motor_drive %b, expected %b",
                                    res_if.motor_drive, want.motor_drive));
        if (res_if.running !== want.running)
          report_mismatch($sformatf("running %b, expected %b",
                                    res_if.running, want.running));
      end
      result_count++;
    end
  end

  initial begin : watchdog
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    clk                   = 1'b0;
    rst                   = 1'b1;
    cmd_if.valid          = 1'b0;
    cmd_if.func           = vps_pkg::FUNC_TICK;
    cmd_if.pattern_select = 2'd0;
    cmd_if.repeat_mode    = 1'b0;
    cmd_if.now_ms         = '0;
    res_if.ready          = 1'b0;
    src_idle_pct          = 0;
    snk_stall_pct         = 0;
    error_count           = 0;
    result_count          = 0;
    cur_ms                = 32'd5000;
    seq_active            = 1'b0;
    seq_repeat            = 1'b0;
    seq_pattern           = 2'd0;
    seq_step              = '0;
    seq_deadline          = '0;
    seq_phase_on          = 1'b0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int unsigned i = 0; i < PLAN_LEN; i++)
      drive_command(OPENING_PLAN[i].cmd, OPENING_PLAN[i].fixed,
                    OPENING_PLAN[i].motor_drive, OPENING_PLAN[i].running);

    run_random_mix(ITEMS_PER_MIX);
    src_idle_pct  = 52;
    run_random_mix(ITEMS_PER_MIX);
    src_idle_pct  = 0;
    snk_stall_pct = 52;
    run_random_mix(ITEMS_PER_MIX);
    src_idle_pct  = 34;
    snk_stall_pct = 34;
    run_random_mix(ITEMS_PER_MIX);

    cmd_if.valid <= 1'b0;
    while (pending_cmds.size() != 0 || motor_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
